// ----- hdl/mbcb_pkg.sv -----
package mbcb_pkg;

   localparam int CFG_W       = 11;
   localparam int CFG_MAX     = (1 << CFG_W) - 1;
   localparam int BYTE_W      = 8;
   localparam int ADDR_W      = 17;
   localparam int CSR_IDX_W   = 3;
   localparam int MAX_DIM_DEF = 1024;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [CFG_W-1:0] DEST_WIDTH_RST  = 11'd320;
   localparam logic [CFG_W-1:0] DEST_HEIGHT_RST = 11'd200;
   localparam logic [CFG_W-1:0] COPY_WIDTH_RST  = 11'd8;
   localparam logic [CFG_W-1:0] COPY_HEIGHT_RST = 11'd1;
   localparam logic [CFG_W-1:0] POS_X_RST       = 11'd0;
   localparam logic [CFG_W-1:0] POS_Y_RST       = 11'd0;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_DEST_WIDTH  = 3'd0,
      REG_DEST_HEIGHT = 3'd1,
      REG_COPY_WIDTH  = 3'd2,
      REG_COPY_HEIGHT = 3'd3,
      REG_POS_X       = 3'd4,
      REG_POS_Y       = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [BYTE_W-1:0] data;
      logic [BYTE_W-1:0] mask;
   } write_type;

   // one classified source byte: one or two writes, w0 goes out first
   typedef struct packed {
      logic      two;
      logic      last;
      write_type w0;
      write_type w1;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } head_type;

   // saturate a dimension register to 1..maxd
   function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                  input int unsigned maxd);
      logic [CFG_W-1:0] res;
      res = v;
      if (v == '0) begin
         res = CFG_W'(1);
      end else if (32'(v) > maxd) begin
         res = CFG_W'(maxd);
      end
      return res;
   endfunction

endpackage

// ----- hdl/mbcb_if.sv -----
interface mbcb_req_if import mbcb_pkg::*;;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] source_byte;

   modport source (output valid, output source_byte, input ready);
   modport sink (input valid, input source_byte, output ready);
endinterface

interface mbcb_rsp_if import mbcb_pkg::*;;
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] dest_byte_addr;
   logic [BYTE_W-1:0] write_data;
   logic [BYTE_W-1:0] bit_mask;
   logic              last_write;

   modport source (output valid, output dest_byte_addr, output write_data,
                   output bit_mask, output last_write, input ready);
   modport sink (input valid, input dest_byte_addr, input write_data,
                 input bit_mask, input last_write, output ready);
endinterface

// ----- hdl/mono_bitmap_clipped_blit.sv -----
// A taken source beat is pushed into the job queue and then into the output register.
// Throughput: one source beat per cycle while the queue is not full and each byte makes
// at most one write; the output register issues one write per cycle while the sink is
// ready; a row-end byte's two writes are absorbed by a 4-entry job queue.
// Reset (synchronous, active high) restores the register defaults, clears the row and
// column counters, the bit carry, the queue and the output valid; it has no sweep.
module mono_bitmap_clipped_blit import mbcb_pkg::*; #(
   parameter int MAX_DIM = MAX_DIM_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   mbcb_req_if.sink             req_chan,
   mbcb_rsp_if.source           rsp_chan
);

   logic     q_full;
   logic     push;
   job_type  push_job;
   logic     pop;
   head_type head;

   mbcb_front #(.MAX_DIM(MAX_DIM)) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req       (req_chan),
      .q_full    (q_full),
      .push      (push),
      .push_job  (push_job)
   );

   mbcb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (pop),
      .head     (head)
   );

   mbcb_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .pop   (pop),
      .rsp   (rsp_chan)
   );

endmodule

// ----- hdl/mbcb_front.sv -----
module mbcb_front import mbcb_pkg::*; #(
   parameter int MAX_DIM = MAX_DIM_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   mbcb_req_if.sink             req,
   input  logic                 q_full,
   output logic                 push,
   output job_type              push_job
);

   localparam int DIM_MAX  = (MAX_DIM < CFG_MAX) ? MAX_DIM : CFG_MAX;
   localparam int COL_W    = $clog2((DIM_MAX + 7) / 8 + 1);
   localparam int ROW_W    = $clog2(DIM_MAX + 1);
   localparam int Y_W      = CFG_W + 2;
   localparam int X_W      = CFG_W + 3;
   localparam int STRIDE_W = CFG_W - 2;
   localparam int PROD_W   = CFG_W + STRIDE_W;

   logic [CFG_W-1:0]  dw_ff, dh_ff, cw_ff, ch_ff, pos_x_ff, pos_y_ff;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [BYTE_W-1:0] carry_ff, carry_in, pmask_ff, pmask_in;

   logic                accept;
   logic                row_wrap, col_wrap;
   logic [COL_W-1:0]    bpr, col_eff;
   logic [ROW_W-1:0]    row_eff;
   logic [BYTE_W-1:0]   carry_d, carry_m;
   logic [Y_W-1:0]      dy;
   logic                rowok;
   logic [CFG_W:0]      words_sum;
   logic [STRIDE_W-1:0] stride;
   logic [PROD_W-1:0]   prod;
   logic [ADDR_W-1:0]   row_base, dcol, addr0, addr1;
   logic [X_W-1:0]      base_x, dx;
   logic [CFG_W:0]      sx_base, sx;
   logic [BYTE_W-1:0]   vm;
   logic [2:0]          shift;
   logic [2*BYTE_W-1:0] src_sh, vm_sh;
   logic [BYTE_W-1:0]   hi_d, hi_m, lo_d, lo_m;
   logic                hi_v, lo_v, last_in_row, last_blit;
   write_type           wr_hi, wr_lo;

   assign req.ready = !q_full;
   assign accept    = req.valid && req.ready;

   // counters left beyond a shrunk rectangle restart from zero
   always_comb begin
      bpr      = COL_W'((12'(cw_ff) + 12'd7) >> 3);
      row_wrap = CFG_W'(row_ff) >= ch_ff;
      col_wrap = row_wrap || (col_ff >= bpr);
      row_eff  = row_wrap ? '0 : row_ff;
      col_eff  = col_wrap ? '0 : col_ff;
      carry_d  = col_wrap ? '0 : carry_ff;
      carry_m  = col_wrap ? '0 : pmask_ff;
   end

   always_comb begin
      dy        = {{2{pos_y_ff[CFG_W-1]}}, pos_y_ff} + Y_W'(row_eff);
      rowok     = !dy[Y_W-1] && (dy[Y_W-2:0] < (Y_W-1)'(dh_ff));
      words_sum = (CFG_W+1)'(dw_ff) + (CFG_W+1)'(31);
      stride    = {words_sum[CFG_W:5], 2'b00};
      prod      = PROD_W'(dy[CFG_W-1:0]) * PROD_W'(stride);
      row_base  = rowok ? prod[ADDR_W-1:0] : '0;
   end

   // per-pixel visibility of this byte
   always_comb begin
      base_x  = {{3{pos_x_ff[CFG_W-1]}}, pos_x_ff} + X_W'({col_eff, 3'b000});
      sx_base = (CFG_W+1)'({col_eff, 3'b000});
      sx      = sx_base;
      dx      = base_x;
      vm      = '0;
      for (int i = 0; i < BYTE_W; i++) begin
         sx = sx_base + (CFG_W+1)'(i);
         dx = base_x + X_W'(i);
         vm[BYTE_W-1-i] = rowok && (sx < (CFG_W+1)'(cw_ff)) && !dx[X_W-1] &&
                          (dx[X_W-2:0] < (X_W-1)'(dw_ff));
      end
   end

   always_comb begin
      shift  = pos_x_ff[2:0];
      src_sh = {req.source_byte, {BYTE_W{1'b0}}} >> shift;
      vm_sh  = {vm, {BYTE_W{1'b0}}} >> shift;
      hi_d   = carry_d | src_sh[2*BYTE_W-1:BYTE_W];
      hi_m   = carry_m | vm_sh[2*BYTE_W-1:BYTE_W];
      lo_d   = src_sh[BYTE_W-1:0];
      lo_m   = vm_sh[BYTE_W-1:0];
      dcol   = {{(ADDR_W-CFG_W+3){pos_x_ff[CFG_W-1]}}, pos_x_ff[CFG_W-1:3]} +
               ADDR_W'(col_eff);
      addr0  = row_base + dcol;
      addr1  = addr0 + ADDR_W'(1);

      last_in_row = ((COL_W+1)'(col_eff) + (COL_W+1)'(1)) == (COL_W+1)'(bpr);
      last_blit   = last_in_row && ((CFG_W'(row_eff) + CFG_W'(1)) == ch_ff);
      hi_v        = hi_m != '0;
      lo_v        = last_in_row && (lo_m != '0);

      wr_hi = '{addr: addr0, data: hi_d & hi_m, mask: hi_m};
      wr_lo = '{addr: addr1, data: lo_d & lo_m, mask: lo_m};
   end

   // pack the writes so that w0 is always the first one out
   always_comb begin
      push_job.last = last_blit;
      push_job.w1   = wr_lo;
      if (hi_v) begin
         push_job.two = lo_v;
         push_job.w0  = wr_hi;
      end else if (lo_v) begin
         push_job.two = 1'b0;
         push_job.w0  = wr_lo;
      end else begin
         // nothing visible: a blank beat still flags completion
         push_job.two = 1'b0;
         push_job.w0  = '0;
      end
      push = accept && (hi_v || lo_v || last_blit);
   end

   always_comb begin
      if (last_in_row) begin
         carry_in = '0;
         pmask_in = '0;
         col_in   = '0;
         row_in   = last_blit ? '0 : row_eff + ROW_W'(1);
      end else begin
         carry_in = lo_d;
         pmask_in = lo_m;
         col_in   = col_eff + COL_W'(1);
         row_in   = row_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dw_ff    <= DEST_WIDTH_RST;
         dh_ff    <= DEST_HEIGHT_RST;
         cw_ff    <= COPY_WIDTH_RST;
         ch_ff    <= COPY_HEIGHT_RST;
         pos_x_ff <= POS_X_RST;
         pos_y_ff <= POS_Y_RST;
         col_ff   <= '0;
         row_ff   <= '0;
         carry_ff <= '0;
         pmask_ff <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_DEST_WIDTH:  dw_ff    <= clamp_dim(csr_wdata, DIM_MAX);
               REG_DEST_HEIGHT: dh_ff    <= clamp_dim(csr_wdata, DIM_MAX);
               REG_COPY_WIDTH:  cw_ff    <= clamp_dim(csr_wdata, DIM_MAX);
               REG_COPY_HEIGHT: ch_ff    <= clamp_dim(csr_wdata, DIM_MAX);
               REG_POS_X:       pos_x_ff <= csr_wdata;
               REG_POS_Y:       pos_y_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (accept) begin
            col_ff   <= col_in;
            row_ff   <= row_in;
            carry_ff <= carry_in;
            pmask_ff <= pmask_in;
         end
      end
   end

endmodule

// ----- hdl/mbcb_queue.sv -----
module mbcb_queue import mbcb_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  job_type  push_job,
   output logic     full,
   input  logic     pop,
   output head_type head
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign full       = count_ff == CNT_W'(QUEUE_DEPTH);
   assign head.valid = count_ff != '0;
   assign head.job   = entry_ff[rptr_ff];
   assign do_pop     = pop && head.valid;

   always_comb begin
      wptr_in  = push ? wptr_ff + PTR_W'(1) : wptr_ff;
      rptr_in  = do_pop ? rptr_ff + PTR_W'(1) : rptr_ff;
      count_in = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!push && do_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wptr_ff] <= push_job;
      end
   end

endmodule

// ----- hdl/mbcb_back.sv -----
module mbcb_back import mbcb_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  head_type head,
   output logic     pop,
   mbcb_rsp_if.source rsp
);

   logic              valid_ff, valid_in;
   logic              idx_ff, idx_in;
   logic [ADDR_W-1:0] addr_ff;
   logic [BYTE_W-1:0] data_ff, mask_ff;
   logic              last_ff;
   logic              load, done;
   write_type         cur;

   // output register takes a new beat when empty or being drained
   assign load = head.valid && (!valid_ff || rsp.ready);
   assign done = idx_ff || !head.job.two;
   assign pop  = load && done;
   assign cur  = idx_ff ? head.job.w1 : head.job.w0;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff && !rsp.ready;
      if (load) begin
         idx_in   = !done;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         addr_ff <= cur.addr;
         data_ff <= cur.data;
         mask_ff <= cur.mask;
         last_ff <= head.job.last && done;
      end
   end

   assign rsp.valid          = valid_ff;
   assign rsp.dest_byte_addr = addr_ff;
   assign rsp.write_data     = data_ff;
   assign rsp.bit_mask       = mask_ff;
   assign rsp.last_write     = last_ff;

endmodule

// ----- hdl/mbcb_checker.sv -----
module mbcb_checker import mbcb_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [ADDR_W-1:0] rsp_dest_byte_addr,
   input logic [BYTE_W-1:0] rsp_write_data,
   input logic [BYTE_W-1:0] rsp_bit_mask,
   input logic              rsp_last_write
);

   // stalled beat holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_dest_byte_addr) && $stable(rsp_write_data) &&
         $stable(rsp_bit_mask) && $stable(rsp_last_write))
      else $error("rsp payload changed while stalled");

   // data never carries bits the mask leaves alone
   a_data_in_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_write_data & ~rsp_bit_mask) == '0)
      else $error("write_data outside bit_mask");

   // an empty mask only appears as the blank completion beat
   a_blank_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bit_mask == '0 |->
         rsp_last_write && rsp_dest_byte_addr == '0 && rsp_write_data == '0)
      else $error("empty-mask beat is not a blank completion");

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind mono_bitmap_clipped_blit mbcb_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_dest_byte_addr (rsp_chan.dest_byte_addr),
   .rsp_write_data     (rsp_chan.write_data),
   .rsp_bit_mask       (rsp_chan.bit_mask),
   .rsp_last_write     (rsp_chan.last_write)
);

// ----- verif/mbcb_write_check.sv -----
`timescale 1ns / 1ps

module mbcb_write_check import mbcb_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   mbcb_req_if                  req_chan,
   mbcb_rsp_if                  rsp_chan,
   output int                   mismatches,
   output int                   outstanding
);

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [BYTE_W-1:0] data;
      logic [BYTE_W-1:0] mask;
      logic              last;
   } dest_write_type;

   dest_write_type dest_writes_due[$];

   logic [CFG_W-1:0] dest_w_reg, dest_h_reg, copy_w_reg, copy_h_reg, pos_x_reg, pos_y_reg;
   int unsigned      col_byte, src_row;
   logic [7:0]       carry_data, carry_mask;
   int               fail_count = 0;

   function automatic int unsigned sat_dim(input logic [CFG_W-1:0] v);
      if (v == '0) return 1;
      if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
      return v;
   endfunction

   task automatic report_error(input string what, input int got, input int want);
      $display("%0t ERROR %s: got 0x%0h want 0x%0h", $time, what, got, want);
      fail_count++;
   endtask

   // one source beat -> zero, one or two masked destination writes
   task automatic place_source_byte(input logic [7:0] src);
      int unsigned dw, dh, cw, ch, bpr, stride, shift, row_base;
      int          px, py, dy, dx, dcol, i, n;
      logic [7:0]  vis, hi_data, hi_mask, lo_data, lo_mask;
      logic        row_ok, row_end, blit_end;
      dest_write_type w;
      dw = sat_dim(dest_w_reg);
      dh = sat_dim(dest_h_reg);
      cw = sat_dim(copy_w_reg);
      ch = sat_dim(copy_h_reg);
      bpr = (cw + 7) / 8;
      stride = ((dw + 31) / 32) * 4;
      px = $signed(pos_x_reg);
      py = $signed(pos_y_reg);
      n = 0;

      // counters beyond a shrunken rectangle restart
      if (src_row >= ch) begin
         src_row = 0;
         col_byte = 0;
         carry_data = '0;
         carry_mask = '0;
      end
      if (col_byte >= bpr) begin
         col_byte = 0;
         carry_data = '0;
         carry_mask = '0;
      end

      dy = py + int'(src_row);
      row_ok = dy >= 0 && dy < int'(dh);
      row_base = row_ok ? dy * stride : 0;

      vis = '0;
      for (i = 0; i < 8; i++) begin
         dx = px + int'(8 * col_byte) + i;
         if (row_ok && (8 * col_byte + i) < cw && dx >= 0 && dx < int'(dw))
            vis[7 - i] = 1'b1;
      end

      shift = (px + 1024) % 8;
      dcol = (px + 1024) / 8 - 128 + int'(col_byte);

      hi_data = carry_data | (src >> shift);
      hi_mask = carry_mask | (vis >> shift);
      if (hi_mask != '0) begin
         dest_writes_due.push_back('{ADDR_W'(int'(row_base) + dcol), hi_data & hi_mask,
                                    hi_mask, 1'b0});
         n++;
      end

      lo_data = '0;
      lo_mask = '0;
      if (shift != 0) begin
         lo_data = src << (8 - shift);
         lo_mask = vis << (8 - shift);
      end

      row_end = (col_byte + 1 == bpr);
      blit_end = row_end && (src_row + 1 == ch);

      if (row_end) begin
         if (lo_mask != '0) begin
            dest_writes_due.push_back('{ADDR_W'(int'(row_base) + dcol + 1), lo_data & lo_mask,
                                       lo_mask, 1'b0});
            n++;
         end
         carry_data = '0;
         carry_mask = '0;
         col_byte = 0;
         src_row = (src_row + 1 == ch) ? 0 : src_row + 1;
      end else begin
         carry_data = lo_data;
         carry_mask = lo_mask;
         col_byte++;
      end

      // completion is flagged even when the blit touched nothing
      if (blit_end) begin
         if (n == 0)
            dest_writes_due.push_back('0);
         w = dest_writes_due.pop_back();
         w.last = 1'b1;
         dest_writes_due.push_back(w);
      end
   endtask

   task automatic check_write();
      dest_write_type want;
      if (dest_writes_due.size() == 0) begin
         report_error("unexpected write", int'(rsp_chan.dest_byte_addr), 0);
         return;
      end
      want = dest_writes_due.pop_front();
      if (rsp_chan.dest_byte_addr !== want.addr)
         report_error("dest_byte_addr", int'(rsp_chan.dest_byte_addr), int'(want.addr));
      if (rsp_chan.write_data !== want.data)
         report_error("write_data", int'(rsp_chan.write_data), int'(want.data));
      if (rsp_chan.bit_mask !== want.mask)
         report_error("bit_mask", int'(rsp_chan.bit_mask), int'(want.mask));
      if (rsp_chan.last_write !== want.last)
         report_error("last_write", int'(rsp_chan.last_write), int'(want.last));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         dest_w_reg = DEST_WIDTH_RST;
         dest_h_reg = DEST_HEIGHT_RST;
         copy_w_reg = COPY_WIDTH_RST;
         copy_h_reg = COPY_HEIGHT_RST;
         pos_x_reg = POS_X_RST;
         pos_y_reg = POS_Y_RST;
         col_byte = 0;
         src_row = 0;
         carry_data = '0;
         carry_mask = '0;
         dest_writes_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_DEST_WIDTH:  dest_w_reg = csr_wdata;
               REG_DEST_HEIGHT: dest_h_reg = csr_wdata;
               REG_COPY_WIDTH:  copy_w_reg = csr_wdata;
               REG_COPY_HEIGHT: copy_h_reg = csr_wdata;
               REG_POS_X:       pos_x_reg = csr_wdata;
               REG_POS_Y:       pos_y_reg = csr_wdata;
               default: ;
            endcase
         end
         if (req_chan.valid && req_chan.ready)
            place_source_byte(req_chan.source_byte);
         if (rsp_chan.valid && rsp_chan.ready)
            check_write();
      end
      outstanding = dest_writes_due.size();
      mismatches = fail_count;
   end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import mbcb_pkg::*;

   localparam int TARGET_BYTES = 1900;
   localparam int QUIET_LIMIT  = 1000;
   localparam int SETTLE       = 4;
   localparam int MAX_BURST    = 300;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;
   int                   mismatches, outstanding;
   int                   send_gap_pct = 38;
   int                   sink_stall_pct = 38;
   int                   bytes_sent = 0;
   int                   quiet_cycles = 0;
   int                   blit_len;

   mbcb_req_if req_chan();
   mbcb_rsp_if rsp_chan();

   mono_bitmap_clipped_blit i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   mbcb_write_check i_write_check (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_chan.ready <= !reset && ($urandom_range(99) >= sink_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("mono_bitmap_clipped_blit test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic int unsigned clipped_dim(input logic [CFG_W-1:0] v);
      if (v == '0) return 1;
      if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
      return v;
   endfunction

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_gap_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.source_byte <= b;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      bytes_sent++;
      @(negedge clock);
   endtask

   // hold off the sender until every write is out and the pipe is quiet
   task automatic drain();
      req_chan.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [CFG_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
   endtask

   task automatic load_blit(input int dw, input int dh, input int cw, input int ch,
                            input int px, input int py);
      drain();
      write_reg(REG_DEST_WIDTH, CFG_W'(dw));
      write_reg(REG_DEST_HEIGHT, CFG_W'(dh));
      write_reg(REG_COPY_WIDTH, CFG_W'(cw));
      write_reg(REG_COPY_HEIGHT, CFG_W'(ch));
      write_reg(REG_POS_X, CFG_W'(px));
      write_reg(REG_POS_Y, CFG_W'(py));
      csr_we <= 1'b0;
      blit_len = ((clipped_dim(CFG_W'(cw)) + 7) / 8) * clipped_dim(CFG_W'(ch));
   endtask

   initial begin
      int pick, dw, dh, cw, ch, px, py, burst;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = REG_DEST_WIDTH;
      csr_wdata = '0;
      req_chan.valid = 1'b0;
      req_chan.source_byte = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset configuration, one byte blit
      send_byte(8'hA5);
      // shifted two-byte row, oversized height saturates
      load_blit(1024, 2047, 13, 1, 3, 0);
      send_byte(8'hFF);
      send_byte(8'h00);
      // blit entirely off the left edge: only the completion write
      load_blit(320, 200, 8, 2, -1024, 0);
      send_byte(8'h5A);
      send_byte(8'hC3);
      // right and bottom edges of the largest destination
      load_blit(1024, 1024, 16, 1, 1020, 1023);
      send_byte(8'h00);
      send_byte(8'hFF);
      // zero dimensions saturate to one
      load_blit(0, 0, 0, 0, 0, 0);
      send_byte(8'h80);
      load_blit(1, 1, 1, 1, 1023, -1024);
      send_byte(8'h7F);
      // rectangle shrinks while a row is half done
      load_blit(64, 8, 24, 2, 5, 1);
      send_byte(8'h81);
      send_byte(8'h3C);
      load_blit(64, 8, 8, 2, 5, 1);
      send_byte(8'hE7);
      send_byte(8'h18);
      // clipped on left and top
      load_blit(40, 4, 20, 3, -3, -1);
      send_byte(8'h55);
      send_byte(8'hAA);
      send_byte(8'hF0);
      send_byte(8'h0F);
      send_byte(8'h01);
      send_byte(8'h80);

      while (bytes_sent < TARGET_BYTES) begin
         if (bytes_sent >= 600 && bytes_sent < 1000) begin
            send_gap_pct = 0;
            sink_stall_pct = 0;
         end else begin
            send_gap_pct = 38;
            sink_stall_pct = 38;
         end

         pick = $urandom_range(99);
         if (pick < 8) begin
            // any register bit pattern, out-of-range dimensions included
            dw = $urandom_range(CFG_MAX);
            dh = $urandom_range(CFG_MAX);
            cw = $urandom_range(CFG_MAX);
            ch = $urandom_range(CFG_MAX);
            px = $urandom_range(CFG_MAX);
            py = $urandom_range(CFG_MAX);
         end else begin
            dw = (pick < 14) ? 1024 : (pick < 18) ? 1 : $urandom_range(1, 160);
            dh = $urandom_range(1, 40);
            cw = (pick >= 92) ? $urandom_range(41, 1024) : $urandom_range(1, 40);
            ch = (cw > 64) ? 1 : $urandom_range(1, 4);
            px = int'($urandom_range(0, dw + 48)) - 24;
            py = int'($urandom_range(0, dh + 4)) - 2;
            if (pick == 20) px = -1024;
            if (pick == 21) px = 1023;
            if (px > 1023) px = 1023;
            if (py > 1023) py = 1023;
         end
         load_blit(dw, dh, cw, ch, px, py);

         burst = blit_len * $urandom_range(1, 4);
         pick = $urandom_range(9);
         if (pick == 0)
            burst = $urandom_range(1, burst);   // cut off mid-blit
         else if (pick == 1)
            burst = burst + $urandom_range(1, blit_len);
         if (burst > MAX_BURST) burst = MAX_BURST;
         repeat (burst) send_byte(8'($urandom));
      end

      drain();
      repeat (8) @(negedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("mono_bitmap_clipped_blit test passed");
      end else begin
         $display("mono_bitmap_clipped_blit test failed");
      end
      $finish;
   end

endmodule
